### rtl/tsg_pkg.sv
// Shared types, codes and widths for the touch swipe gesture recognizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tsg_pkg;

  // Width of the stored coordinates (8 to 32).
  localparam int COORD_BITS = 16;
  // Width of the event value and of the reported points.
  localparam int VAL_BITS   = 16;
  // Width of the hit-rectangle bounds.
  localparam int RECT_BITS  = 16;
  // Common width for comparing coordinates against the rectangle.
  localparam int CMP_BITS   = (COORD_BITS > RECT_BITS) ? COORD_BITS : RECT_BITS;

  // APB register file
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 4;
  localparam int REG_IDX_BITS  = 2;

  localparam logic [REG_IDX_BITS-1:0] REG_RECT_LEFT   = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_RECT_TOP    = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_RECT_RIGHT  = 2'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_RECT_BOTTOM = 2'd3;

  // Event kinds
  localparam logic [1:0] REQ_OTHER = 2'd0;
  localparam logic [1:0] REQ_KEY   = 2'd1;
  localparam logic [1:0] REQ_X     = 2'd2;
  localparam logic [1:0] REQ_Y     = 2'd3;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_UP    = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_t;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } points_t;

  typedef struct packed {
    logic [RECT_BITS-1:0] left;
    logic [RECT_BITS-1:0] top;
    logic [RECT_BITS-1:0] right;
    logic [RECT_BITS-1:0] bottom;
  } rect_t;

endpackage

`default_nettype wire

### rtl/tsg_cfg.sv
// APB register file holding the hit rectangle bounds.
// Depends on tsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsg_cfg
  import tsg_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready,
  output rect_t                         rect
);

  rect_t                   rect_q;
  logic [REG_IDX_BITS-1:0] idx;
  logic                    wr_en;

  assign idx    = paddr[APB_ADDR_BITS-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign rect   = rect_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_RECT_LEFT:   rect_q.left   <= pwdata[RECT_BITS-1:0];
        REG_RECT_TOP:    rect_q.top    <= pwdata[RECT_BITS-1:0];
        REG_RECT_RIGHT:  rect_q.right  <= pwdata[RECT_BITS-1:0];
        REG_RECT_BOTTOM: rect_q.bottom <= pwdata[RECT_BITS-1:0];
        default:         rect_q        <= rect_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_RECT_LEFT:   prdata = APB_DATA_BITS'(rect_q.left);
      REG_RECT_TOP:    prdata = APB_DATA_BITS'(rect_q.top);
      REG_RECT_RIGHT:  prdata = APB_DATA_BITS'(rect_q.right);
      REG_RECT_BOTTOM: prdata = APB_DATA_BITS'(rect_q.bottom);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/tsg_track.sv
// Gesture state: press phase and the start/end points, updated per item.
// Depends on tsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsg_track
  import tsg_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                upd_en,
  input  wire logic [1:0]          req_type,
  input  wire logic [VAL_BITS-1:0] event_value,
  output points_t                  points
);

  points_t pts;
  points_t pts_next;
  logic    awaiting_press;
  logic    awaiting_press_next;
  coord_t  coord;

  assign coord  = COORD_BITS'(event_value);
  assign points = pts;

  always_comb begin
    pts_next            = pts;
    awaiting_press_next = awaiting_press;
    unique case (req_type)
      REQ_KEY: begin
        if (event_value != '0) begin
          awaiting_press_next = 1'b0;
        end else begin
          // release: result is taken from the old points, then start over
          awaiting_press_next = 1'b1;
          pts_next            = '0;
        end
      end
      REQ_X: begin
        if (coord != '0) begin
          if (awaiting_press) pts_next.start_x = coord;
          pts_next.end_x = coord;
        end
      end
      REQ_Y: begin
        if (coord != '0) begin
          if (awaiting_press) pts_next.start_y = coord;
          pts_next.end_y = coord;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_press <= 1'b1;
      pts            <= '0;
    end else if (upd_en) begin
      awaiting_press <= awaiting_press_next;
      pts            <= pts_next;
    end
  end

endmodule

`default_nettype wire

### rtl/tsg_eval.sv
// Swipe direction and rectangle hit test from the current points.
// Depends on tsg_pkg; purely combinational.
`timescale 1ns / 1ps
`default_nettype none

module tsg_eval
  import tsg_pkg::*;
(
  input  wire points_t points,
  input  wire rect_t   rect,
  output dir_t         direction,
  output logic         in_rect
);

  coord_t                dx;
  coord_t                dy;
  logic                  same_x;
  logic                  same_y;
  logic [CMP_BITS-1:0]   sx;
  logic [CMP_BITS-1:0]   sy;

  assign same_x = (points.start_x == points.end_x);
  assign same_y = (points.start_y == points.end_y);

  assign dx = (points.end_x > points.start_x) ? (points.end_x - points.start_x)
                                              : (points.start_x - points.end_x);
  assign dy = (points.end_y > points.start_y) ? (points.end_y - points.start_y)
                                              : (points.start_y - points.end_y);

  always_comb begin
    if (same_x && same_y) begin
      direction = DIR_NONE;
    end else if (dx > dy) begin
      direction = (points.end_x > points.start_x) ? DIR_RIGHT : DIR_LEFT;
    end else begin
      // ties go to the vertical axis
      direction = (points.end_y > points.start_y) ? DIR_DOWN : DIR_UP;
    end
  end

  assign sx = CMP_BITS'(points.start_x);
  assign sy = CMP_BITS'(points.start_y);

  // diagonal gestures never count as a hit
  assign in_rect = (same_x || same_y) &&
                   (sx > CMP_BITS'(rect.left))  && (sx < CMP_BITS'(rect.right)) &&
                   (sy > CMP_BITS'(rect.top))   && (sy < CMP_BITS'(rect.bottom));

endmodule

`default_nettype wire

### rtl/touch_swipe_gesture_recognizer_unit.sv
// Top level of the touch swipe gesture recognizer: input register, gesture
// state, direction/hit logic, result register and APB configuration.
// Depends on tsg_pkg, tsg_cfg, tsg_track and tsg_eval.
`timescale 1ns / 1ps
`default_nettype none

// Touch swipe gesture recognizer. Each input item is one touch-panel event
// (req_type: other, key, X sample, Y sample; event_value: key state or
// coordinate). Before the key press a nonzero sample sets both the start and
// end coordinate of its axis; after the press only the end coordinate moves.
// Zero samples and "other" events change nothing. A key release (key event
// with value 0), pressed or not, produces exactly one result item carrying
// the start point (begin_x/y), end point (finish_x/y), swipe direction
// (none/up/down/left/right by the larger absolute delta, vertical on a tie)
// and in_rect, set when the gesture did not move on both axes and its start
// lies strictly inside the rectangle programmed over APB (rect_left at 0x0,
// rect_top at 0x4, rect_right at 0x8, rect_bottom at 0xC, all reset to 0).
// Rate: one item per clock. An accepted item waits in the input register,
// then updates the state and, for a release, loads the result register.
// A release waits in the input register while the result register holds an
// item not yet taken; this is the only source of input back-pressure.
// Configure only while no item is in flight.
module touch_swipe_gesture_recognizer_unit
  import tsg_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // event input
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               req_type,
  input  wire logic [VAL_BITS-1:0]      event_value,
  // result output
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic      [2:0]               direction,
  output logic                          in_rect,
  output logic      [VAL_BITS-1:0]      begin_x,
  output logic      [VAL_BITS-1:0]      begin_y,
  output logic      [VAL_BITS-1:0]      finish_x,
  output logic      [VAL_BITS-1:0]      finish_y,
  // configuration
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready
);

  // input register
  logic                s1_valid;
  logic                s1_valid_next;
  logic [1:0]          s1_type;
  logic [VAL_BITS-1:0] s1_value;
  logic                s1_release;
  logic                s1_adv;

  // result register
  logic                out_valid_q;
  logic                out_valid_next;
  logic                out_load;
  dir_t                dir_q;
  logic                in_rect_q;
  points_t             pts_q;

  rect_t               rect;
  points_t             points;
  dir_t                eval_dir;
  logic                eval_in_rect;

  tsg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rect    (rect)
  );

  // A release leaves the input register only when the result slot is free
  // or being emptied this cycle; every other item never waits.
  assign s1_release    = (s1_type == REQ_KEY) && (s1_value == '0);
  assign s1_adv        = s1_valid && (!s1_release || !out_valid_q || out_ready);
  assign in_ready      = !s1_valid || s1_adv;
  assign s1_valid_next = (in_valid && in_ready) || (s1_valid && !s1_adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_type  <= req_type;
      s1_value <= event_value;
    end
  end

  tsg_track u_track (
    .clk         (clk),
    .rst         (rst),
    .upd_en      (s1_adv),
    .req_type    (s1_type),
    .event_value (s1_value),
    .points      (points)
  );

  // evaluated on the points as they stand before the release clears them
  tsg_eval u_eval (
    .points    (points),
    .rect      (rect),
    .direction (eval_dir),
    .in_rect   (eval_in_rect)
  );

  assign out_load       = s1_adv && s1_release;
  assign out_valid_next = out_load || (out_valid_q && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dir_q     <= eval_dir;
      in_rect_q <= eval_in_rect;
      pts_q     <= points;
    end
  end

  assign out_valid = out_valid_q;
  assign direction = dir_q;
  assign in_rect   = in_rect_q;
  assign begin_x   = VAL_BITS'(pts_q.start_x);
  assign begin_y   = VAL_BITS'(pts_q.start_y);
  assign finish_x  = VAL_BITS'(pts_q.end_x);
  assign finish_y  = VAL_BITS'(pts_q.end_y);

endmodule

`default_nettype wire

### tb/sv/touch_swipe_gesture_recognizer_unit_tb.sv
// Self-checking testbench for touch_swipe_gesture_recognizer_unit: directed
// corner cases, random gestures under several hit rectangles, then noise items.
// Depends on tsg_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module touch_swipe_gesture_recognizer_unit_tb;
  import tsg_pkg::*;

  // Cycles with no item moving on either channel before the run is abandoned.
  // Worst correct case is a long sender gap on top of a long result stall.
  localparam int WATCHDOG_LIMIT = 4000;
  // Margin for the input register to empty before touching the rectangle
  // registers.
  localparam int SETTLE_CYCLES  = 4;
  localparam int SHOW_LIMIT     = 10;

  // One expected or observed result item.
  typedef struct packed {
    dir_t                dir;
    logic                in_rect;
    logic [VAL_BITS-1:0] begin_x;
    logic [VAL_BITS-1:0] begin_y;
    logic [VAL_BITS-1:0] finish_x;
    logic [VAL_BITS-1:0] finish_y;
  } swipe_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               req_type = REQ_OTHER;
  logic [VAL_BITS-1:0]      event_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [2:0]               direction;
  logic                     in_rect;
  logic [VAL_BITS-1:0]      begin_x;
  logic [VAL_BITS-1:0]      begin_y;
  logic [VAL_BITS-1:0]      finish_x;
  logic [VAL_BITS-1:0]      finish_y;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  touch_swipe_gesture_recognizer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .event_value(event_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .direction  (direction),
    .in_rect    (in_rect),
    .begin_x    (begin_x),
    .begin_y    (begin_y),
    .finish_x   (finish_x),
    .finish_y   (finish_y),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the gesture state and of the rectangle registers.
  bit      awaiting_touch = 1'b1;
  points_t track_pts = '0;
  rect_t   rect_cfg = '0;

  swipe_t  expected_swipes[$];

  int      items_sent;      // items that changed the gesture state
  int      gestures_run;
  int      swipes_checked;
  int      rect_settings;
  int      fail_count;
  bit      no_idle;         // both sides run flat out while set

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [1:0] random_axis();
    return $urandom_range(0, 1) ? REQ_X : REQ_Y;
  endfunction

  // Coordinate sample for one axis: mostly a small window, often right at
  // a rectangle bound of that axis (bound-1, bound, bound+1), plus full range
  // and the extremes. A bound of 0 can yield a zero sample, which is fine.
  function automatic logic [VAL_BITS-1:0] pick_coord(input logic [1:0] axis);
    int r;
    logic [RECT_BITS-1:0] bound;
    r = $urandom_range(0, 99);
    if (r < 50) return VAL_BITS'($urandom_range(1, 2047));
    if (r < 75) begin
      if (axis == REQ_X) bound = $urandom_range(0, 1) ? rect_cfg.left : rect_cfg.right;
      else bound = $urandom_range(0, 1) ? rect_cfg.top : rect_cfg.bottom;
      return VAL_BITS'(bound + RECT_BITS'($urandom_range(0, 2)) - RECT_BITS'(1));
    end
    if (r < 90) return VAL_BITS'($urandom);
    case ($urandom_range(0, 3))
      0: return VAL_BITS'(1);
      1: return '1;
      2: return VAL_BITS'(16'h8000);
      default: return VAL_BITS'(16'h7FFF);
    endcase
  endfunction

  function automatic coord_t abs_delta(input coord_t a, input coord_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Result that a release produces from the current points.
  function automatic swipe_t swipe_on_release();
    swipe_t s;
    logic   moved_x, moved_y;
    coord_t dx, dy;
    moved_x = track_pts.end_x != track_pts.start_x;
    moved_y = track_pts.end_y != track_pts.start_y;
    dx = abs_delta(track_pts.end_x, track_pts.start_x);
    dy = abs_delta(track_pts.end_y, track_pts.start_y);
    if (!moved_x && !moved_y) begin
      s.dir = DIR_NONE;
    end else if (dx > dy) begin
      s.dir = (track_pts.end_x > track_pts.start_x) ? DIR_RIGHT : DIR_LEFT;
    end else begin
      // tie goes vertical
      s.dir = (track_pts.end_y > track_pts.start_y) ? DIR_DOWN : DIR_UP;
    end
    // diagonal moves never count as a hit; bounds are exclusive
    s.in_rect = !(moved_x && moved_y) &&
                CMP_BITS'(track_pts.start_x) > CMP_BITS'(rect_cfg.left) &&
                CMP_BITS'(track_pts.start_x) < CMP_BITS'(rect_cfg.right) &&
                CMP_BITS'(track_pts.start_y) > CMP_BITS'(rect_cfg.top) &&
                CMP_BITS'(track_pts.start_y) < CMP_BITS'(rect_cfg.bottom);
    s.begin_x  = VAL_BITS'(track_pts.start_x);
    s.begin_y  = VAL_BITS'(track_pts.start_y);
    s.finish_x = VAL_BITS'(track_pts.end_x);
    s.finish_y = VAL_BITS'(track_pts.end_y);
    return s;
  endfunction

  // Apply one accepted item to the shadow state. Returns 1 if the item did
  // something (ignored events, zero samples and repeated presses return 0).
  function automatic bit track_event(input logic [1:0] kind,
                                     input logic [VAL_BITS-1:0] value);
    coord_t c;
    bit     did;
    c = coord_t'(value);
    did = 1'b1;
    case (kind)
      REQ_KEY: begin
        if (value != '0) begin
          did = awaiting_touch;
          awaiting_touch = 1'b0;
        end else begin
          // release, pressed or not: report, then back to reset state
          expected_swipes.push_back(swipe_on_release());
          awaiting_touch = 1'b1;
          track_pts = '0;
        end
      end
      REQ_X: begin
        if (c == '0) begin
          did = 1'b0;
        end else begin
          if (awaiting_touch) track_pts.start_x = c;
          track_pts.end_x = c;
        end
      end
      REQ_Y: begin
        if (c == '0) begin
          did = 1'b0;
        end else begin
          if (awaiting_touch) track_pts.start_y = c;
          track_pts.end_y = c;
        end
      end
      default: did = 1'b0;
    endcase
    return did;
  endfunction

  // Offer one item and hold it until accepted. Called right after a rising
  // edge; returns at the edge that accepted it with valid still high, so a
  // back-to-back item just replaces the payload.
  task automatic send_event(input logic [1:0] kind, input logic [VAL_BITS-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= kind;
    event_value <= value;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (track_event(kind, value)) items_sent++;
  endtask

  // Stop sending and let everything in flight drain out.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_swipes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write, setup then access; junk in the upper data bits must be dropped.
  task automatic apb_write(input logic [REG_IDX_BITS-1:0] idx,
                           input logic [RECT_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'({idx, 2'b00});
    pwdata  <= {(APB_DATA_BITS - RECT_BITS)'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_RECT_LEFT:   rect_cfg.left   = value;
      REG_RECT_TOP:    rect_cfg.top    = value;
      REG_RECT_RIGHT:  rect_cfg.right  = value;
      REG_RECT_BOTTOM: rect_cfg.bottom = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // APB read and compare against the value last written.
  task automatic check_reg(input logic [REG_IDX_BITS-1:0] idx,
                           input logic [RECT_BITS-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_ADDR_BITS'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[RECT_BITS-1:0] !== want) begin
      fail_count++;
      if (fail_count <= SHOW_LIMIT)
        $display("register %0d reads %h, expected %h", idx, prdata[RECT_BITS-1:0], want);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Reprogram the hit rectangle with the block idle, then read it back.
  task automatic program_rect(input rect_t r);
    settle();
    apb_write(REG_RECT_LEFT,   r.left);
    apb_write(REG_RECT_TOP,    r.top);
    apb_write(REG_RECT_RIGHT,  r.right);
    apb_write(REG_RECT_BOTTOM, r.bottom);
    check_reg(REG_RECT_LEFT,   r.left);
    check_reg(REG_RECT_TOP,    r.top);
    check_reg(REG_RECT_RIGHT,  r.right);
    check_reg(REG_RECT_BOTTOM, r.bottom);
    rect_settings++;
  endtask

  function automatic rect_t random_rect();
    rect_t r;
    r.left   = RECT_BITS'($urandom_range(0, 1000));
    r.top    = RECT_BITS'($urandom_range(0, 1000));
    r.right  = r.left + RECT_BITS'($urandom_range(1, 1200));
    r.bottom = r.top + RECT_BITS'($urandom_range(1, 1200));
    return r;
  endfunction

  // One sample slot of a gesture; now and then a zero sample or an
  // unrelated event takes its place.
  task automatic send_sample(input logic [1:0] axis);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) send_event(axis, '0);
    else if (r < 13) send_event(REQ_OTHER, VAL_BITS'($urandom));
    else send_event(axis, pick_coord(axis));
  endtask

  // One random gesture. Most are press / move / release; some are broken
  // (release with no press, double press) and some are equal-delta diagonals.
  task automatic run_gesture();
    int     shape, n, i;
    logic   [1:0] axis;
    bit     mixed;
    coord_t d, ex, ey;
    shape = $urandom_range(0, 99);
    gestures_run++;
    n = $urandom_range(0, 3);
    for (i = 0; i < n; i++) send_sample(random_axis());
    if (shape < 12) begin
      send_event(REQ_KEY, '0);
      return;
    end
    send_event(REQ_KEY, VAL_BITS'($urandom_range(1, 65535)));
    if (shape < 20) send_event(REQ_KEY, VAL_BITS'($urandom_range(1, 65535)));
    if (shape < 28) begin
      // same distance on both axes from the start point
      d  = coord_t'($urandom_range(1, 300));
      ex = (track_pts.start_x > d) ? track_pts.start_x - d : track_pts.start_x + d;
      ey = (track_pts.start_y > d) ? track_pts.start_y - d : track_pts.start_y + d;
      send_event(REQ_X, VAL_BITS'(ex));
      send_event(REQ_Y, VAL_BITS'(ey));
    end else begin
      // straight-line moves keep in_rect live; mixed ones go diagonal
      axis  = random_axis();
      mixed = shape >= 64;
      n     = $urandom_range(0, 4);
      for (i = 0; i < n; i++) send_sample(mixed ? random_axis() : axis);
    end
    send_event(REQ_KEY, '0);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_special_cases();
    // reset rectangle is all zero, so nothing can hit
    send_event(REQ_KEY, '0);                       // release without press, all zero
    send_event(REQ_OTHER, '1);                     // other event ignored
    send_event(REQ_X, '0);                         // zero samples ignored
    send_event(REQ_Y, '0);
    send_event(REQ_X, '1);                         // start at the x extreme
    send_event(REQ_Y, VAL_BITS'(1));
    send_event(REQ_KEY, VAL_BITS'(1));             // press
    send_event(REQ_KEY, '1);                       // repeated press
    send_event(REQ_X, VAL_BITS'(1));
    send_event(REQ_Y, '1);
    send_event(REQ_KEY, '0);                       // equal deltas, goes down
    program_rect('{RECT_BITS'(100), RECT_BITS'(100), RECT_BITS'(1000), RECT_BITS'(1000)});
    send_event(REQ_X, VAL_BITS'(500));
    send_event(REQ_Y, VAL_BITS'(500));
    send_event(REQ_KEY, VAL_BITS'(1));
    send_event(REQ_X, VAL_BITS'(900));
    send_event(REQ_KEY, '0);                       // right, inside
    send_event(REQ_X, VAL_BITS'(101));
    send_event(REQ_Y, VAL_BITS'(999));
    send_event(REQ_KEY, VAL_BITS'(5));
    send_event(REQ_Y, VAL_BITS'(200));
    send_event(REQ_KEY, '0);                       // up, just inside the corner
    send_event(REQ_X, VAL_BITS'(100));
    send_event(REQ_KEY, '0);                       // no movement, on the bound
  endtask

  task automatic test_gesture_phase(input rect_t r, input int n_items, input bit quiet);
    int target;
    program_rect(r);
    no_idle = quiet;
    target = items_sent + n_items;
    while (items_sent < target) run_gesture();
    no_idle = 1'b0;
  endtask

  // Unstructured items: any kind, any value.
  task automatic test_noise_events(input int n_items);
    int   target, r;
    logic [1:0] kind;
    logic [VAL_BITS-1:0] value;
    target = items_sent + n_items;
    while (items_sent < target) begin
      kind = 2'($urandom_range(REQ_OTHER, REQ_Y));
      r = $urandom_range(0, 99);
      if (r < 45) value = VAL_BITS'($urandom);
      else if (r < 75) value = VAL_BITS'($urandom_range(0, 3));
      else value = pick_coord(kind);
      send_event(kind, value);
    end
  endtask

  // ------------------------------------------------------ result checking

  always @(posedge clk) begin : check_swipes
    swipe_t got, want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got = '{dir_t'(direction), in_rect, begin_x, begin_y, finish_x, finish_y};
      if (expected_swipes.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
          $display("unexpected swipe dir=%0d in_rect=%b begin=(%h,%h) finish=(%h,%h)",
                   got.dir, got.in_rect, got.begin_x, got.begin_y, got.finish_x,
                   got.finish_y);
      end else begin
        want = expected_swipes.pop_front();
        swipes_checked++;
        if (got !== want) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT) begin
            $display("swipe %0d expected dir=%0d in_rect=%b begin=(%h,%h) finish=(%h,%h)",
                     swipes_checked, want.dir, want.in_rect, want.begin_x, want.begin_y,
                     want.finish_x, want.finish_y);
            $display("swipe %0d got      dir=%0d in_rect=%b begin=(%h,%h) finish=(%h,%h)",
                     swipes_checked, got.dir, got.in_rect, got.begin_x, got.begin_y,
                     got.finish_x, got.finish_y);
          end
        end
      end
    end
  end

  // Result side back-pressure: bursts of ready with stalls in between.
  initial begin : result_stalls
    int run, stall;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      run = no_idle ? 1 : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Any item moving on either channel restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: nothing moved for %0d cycles, %0d swipes still due",
             WATCHDOG_LIMIT, expected_swipes.size());
    $display("touch_swipe_gesture_recognizer_unit_tb NOT OK");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_special_cases();
    // widest rectangle, no idling on either side
    test_gesture_phase('{RECT_BITS'(0), RECT_BITS'(0), '1, '1}, 220, 1'b1);
    test_gesture_phase(random_rect(), 220, 1'b0);
    // inverted rectangle, can never hit
    test_gesture_phase('{'1, '1, RECT_BITS'(0), RECT_BITS'(0)}, 200, 1'b0);
    // only the single point (501,501) is inside
    test_gesture_phase('{RECT_BITS'(500), RECT_BITS'(500), RECT_BITS'(502), RECT_BITS'(502)},
                       200, 1'b0);
    test_gesture_phase(random_rect(), 220, 1'b0);
    test_noise_events(150);
    settle();

    $display("run covered %0d gestures, %0d state-changing items, %0d rectangle settings",
             gestures_run, items_sent, rect_settings);
    $display("%0d swipe results compared, %0d failures", swipes_checked, fail_count);
    if (fail_count == 0) begin
      $display("touch_swipe_gesture_recognizer_unit_tb OK");
    end else begin
      $display("touch_swipe_gesture_recognizer_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
